### sv/gafts_pkg.sv
// Shared constants and saturating helper of the GA fitness table selector.
`timescale 1ns / 1ps
package gafts_pkg;
  localparam int unsigned MaxPopulationDefault = 1024;
  localparam int unsigned FitW = 32;
  localparam int unsigned SumW = 48;
  localparam int unsigned ShiftW = 33;
  localparam int unsigned IdxOutW = 10;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 11;
  localparam logic [CfgAddrW-1:0] CfgPopSize = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgSelMode = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgShiftEn = 2'd2;
  localparam logic [2:0] ReqWrite = 3'd0;
  localparam logic [2:0] ReqFinalize = 3'd1;
  localparam logic [2:0] ReqSelect = 3'd2;
  localparam logic [2:0] ReqOffer = 3'd3;
  localparam logic [2:0] ReqBest = 3'd4;

  function automatic logic signed [FitW-1:0] sat32(input logic signed [ShiftW+1:0] x);
    logic signed [ShiftW+1:0] hi;
    logic signed [ShiftW+1:0] lo;
    hi = 35'sh0_7FFF_FFFF;
    lo = -35'sh0_8000_0000;
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[FitW-1:0];
  endfunction
endpackage

### sv/gafts_mem.sv
// Fitness table memory with one write port and one registered read port.
`timescale 1ns / 1ps
module gafts_mem import gafts_pkg::*; #(
  parameter int unsigned Depth = MaxPopulationDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AddrW-1:0]       waddr,
  input  logic signed [FitW-1:0] wdata,
  input  logic [AddrW-1:0]       raddr,
  output logic signed [FitW-1:0] rdata
);
  logic signed [FitW-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/ga_fitness_table_selector_core.sv
// Top level: GA fitness table with write, selection, offer, best and finalize.
// Requests: write; offer on a cached worst or with a worst search; best; uniform and roulette select;
// finalize with or without shifting. A roulette select on a non-positive sum and unknown requests
// finish without touching the table.
// One item at a time: busy stays high until the strobe and drops with it.
// After reset a clearing pass zeroes all MAX_POPULATION entries (busy high); no stall.
`timescale 1ns / 1ps
module ga_fitness_table_selector_core import gafts_pkg::*; #(
  parameter int unsigned MAX_POPULATION = MaxPopulationDefault,
  parameter int unsigned AddrW = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1,
  parameter int unsigned CntW = $clog2(MAX_POPULATION + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_req_type,
  input  logic [9:0]                in_entry_index,
  input  logic signed [FitW-1:0]    in_fitness,
  input  logic [31:0]               in_random_word,
  input  logic                      cfg_we,
  input  logic [CfgAddrW-1:0]       cfg_index,
  input  logic [CfgDataW-1:0]       cfg_wdata,
  output logic                      out_valid,
  output logic [IdxOutW-1:0]        out_result_index,
  output logic signed [FitW-1:0]    out_result_fitness,
  output logic                      out_replaced,
  output logic                      out_selection_error
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_WR, S_SCAN, S_UNI, S_THR, S_FSHIFT, S_FSUM, S_OFFER, S_DONE
  } state_t;
  typedef enum logic [1:0] {SC_WORST, SC_BEST, SC_ROUL} scan_t;

  state_t state_r;
  scan_t scan_r;
  logic [CfgDataW-1:0] pop_r;
  logic sel_mode_r, shift_en_r;
  logic signed [SumW-1:0] sum_r, acc_r;
  logic signed [ShiftW-1:0] shift_r;
  logic [AddrW-1:0] worst_r;
  logic worst_known_r;
  logic [2:0] req_r;
  logic [AddrW-1:0] eidx_r;
  logic eidx_ok_r;
  logic signed [FitW-1:0] fit_r;
  logic [31:0] rnd_r;
  logic [CntW-1:0] k_r;
  logic [AddrW-1:0] addr_r;
  logic pend_r;
  logic rv_r;
  logic [AddrW-1:0] pend_addr_r;
  logic signed [FitW-1:0] best_v_r;
  logic [AddrW-1:0] best_i_r;
  logic have_r, fnext_r, phase_r;
  logic [SumW+31:0] prod_r;
  logic [31:0] umod_r;
  logic [5:0] bit_r;
  logic [IdxOutW-1:0] o_idx_r;
  logic signed [FitW-1:0] o_fit_r;
  logic o_rep_r, o_err_r, o_v_r;

  logic we_r;
  logic [AddrW-1:0] waddr_r, raddr;
  logic signed [FitW-1:0] wdata_r, rdata;

  gafts_mem #(.Depth(MAX_POPULATION), .AddrW(AddrW)) u_mem (
    .clk(clk), .we(we_r), .waddr(waddr_r), .wdata(wdata_r), .raddr(raddr), .rdata(rdata)
  );

  logic [CntW-1:0] n;
  logic [1:0] nr;
  always_comb begin
    if (pop_r == '0) begin
      n = CntW'(1);
    end else if ({21'd0, pop_r} > 32'(MAX_POPULATION)) begin
      n = CntW'(MAX_POPULATION);
    end else begin
      n = CntW'(pop_r);
    end
    nr = n[1:0];
  end

  // worst-search scan order: r..n-1 then 0..r-1
  function automatic logic [AddrW-1:0] worst_addr(input logic [CntW-1:0] k,
                                                  input logic [CntW-1:0] nn,
                                                  input logic [1:0] r);
    logic [CntW:0] t;
    t = {1'b0, k} + (CntW+1)'(r);
    if (t >= {1'b0, nn}) begin
      t = t - {1'b0, nn};
    end
    return t[AddrW-1:0];
  endfunction

  logic signed [FitW-1:0] cand;
  assign cand = sat32(35'(fit_r) + 35'(shift_r));

  logic signed [FitW-1:0] shifted;
  assign shifted = sat32(35'(rdata) + 35'(shift_r));

  logic signed [SumW-1:0] acc_nxt;
  logic roul_hit, take_lo, take_hi;
  assign acc_nxt = acc_r + SumW'(rdata);
  assign roul_hit = acc_nxt > $signed({1'b0, prod_r[SumW+30:32]});
  assign take_lo = !have_r || (rdata < best_v_r);
  assign take_hi = !have_r || (rdata > best_v_r);

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    o_v_r <= 1'b0;
    we_r <= 1'b0;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pop_r <= CfgDataW'(1024);
      sel_mode_r <= 1'b1;
      shift_en_r <= 1'b1;
      sum_r <= '0;
      shift_r <= '0;
      worst_r <= '0;
      worst_known_r <= 1'b0;
      k_r <= '0;
      pend_r <= 1'b0;
      o_v_r <= 1'b0;
      we_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgPopSize: begin
            pop_r <= cfg_wdata;
            worst_known_r <= 1'b0;
          end
          CfgSelMode: sel_mode_r <= cfg_wdata[0];
          CfgShiftEn: shift_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          we_r <= 1'b1;
          waddr_r <= k_r[AddrW-1:0];
          wdata_r <= '0;
          if (k_r == CntW'(MAX_POPULATION - 1)) begin
            state_r <= S_IDLE;
          end
          k_r <= k_r + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            req_r <= in_req_type;
            eidx_r <= in_entry_index[AddrW-1:0];
            eidx_ok_r <= {22'd0, in_entry_index} < 32'(n);
            fit_r <= in_fitness;
            rnd_r <= in_random_word;
            o_idx_r <= '0;
            o_fit_r <= '0;
            o_rep_r <= 1'b0;
            o_err_r <= 1'b0;
            k_r <= '0;
            pend_r <= 1'b0;
            rv_r <= 1'b0;
            have_r <= 1'b0;
            phase_r <= 1'b0;
            acc_r <= '0;
            case (in_req_type)
              ReqWrite: begin
                addr_r <= in_entry_index[AddrW-1:0];
                state_r <= S_RD;
              end
              ReqFinalize: begin
                fnext_r <= 1'b1;
                if (shift_en_r) begin
                  scan_r <= SC_WORST;
                  state_r <= S_SCAN;
                end else begin
                  state_r <= S_FSUM;
                end
              end
              ReqSelect: begin
                fnext_r <= 1'b0;
                if (!sel_mode_r) begin
                  umod_r <= '0;
                  bit_r <= 6'd32;
                  state_r <= S_UNI;
                end else if (sum_r <= 0) begin
                  o_err_r <= 1'b1;
                  state_r <= S_DONE;
                end else begin
                  prod_r <= '0;
                  bit_r <= 6'd32;
                  state_r <= S_THR;
                end
              end
              ReqOffer: begin
                fnext_r <= 1'b0;
                if (!worst_known_r || {22'd0, worst_r} >= 32'(n)) begin
                  scan_r <= SC_WORST;
                  state_r <= S_SCAN;
                end else begin
                  addr_r <= worst_r;
                  state_r <= S_RD;
                end
              end
              ReqBest: begin
                fnext_r <= 1'b0;
                scan_r <= SC_BEST;
                state_r <= S_SCAN;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          if (req_r == ReqWrite) begin
            if (eidx_ok_r) begin
              we_r <= 1'b1;
              waddr_r <= eidx_r;
              wdata_r <= fit_r;
              sum_r <= sum_r + SumW'(fit_r) - SumW'(rdata);
              worst_known_r <= 1'b0;
            end
            state_r <= S_DONE;
          end else begin
            o_idx_r <= IdxOutW'(worst_r);
            if (cand > rdata) begin
              we_r <= 1'b1;
              waddr_r <= worst_r;
              wdata_r <= cand;
              sum_r <= sum_r + SumW'(cand) - SumW'(rdata);
              worst_known_r <= 1'b0;
              o_rep_r <= 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_SCAN: begin
          // issue address, then consume its entry once the registered read returns it
          if (k_r < n) begin
            addr_r <= (scan_r == SC_WORST) ? worst_addr(k_r, n, nr) : k_r[AddrW-1:0];
            k_r <= k_r + 1'b1;
          end
          pend_addr_r <= addr_r;
          if (rv_r && scan_r == SC_ROUL && roul_hit) begin
            o_idx_r <= IdxOutW'(pend_addr_r);
            pend_r <= 1'b0;
            rv_r <= 1'b0;
            state_r <= S_DONE;
          end else if (rv_r && !pend_r) begin
            pend_r <= 1'b0;
            rv_r <= 1'b0;
            case (scan_r)
              SC_WORST: begin
                if (fnext_r) begin
                  shift_r <= ShiftW'(1) - ShiftW'(take_lo ? rdata : best_v_r);
                  k_r <= '0;
                  state_r <= S_FSHIFT;
                end else begin
                  worst_r <= take_lo ? pend_addr_r : best_i_r;
                  worst_known_r <= 1'b1;
                  addr_r <= take_lo ? pend_addr_r : best_i_r;
                  state_r <= S_RD;
                end
              end
              SC_BEST: begin
                o_idx_r <= IdxOutW'(take_hi ? pend_addr_r : best_i_r);
                addr_r <= take_hi ? pend_addr_r : best_i_r;
                state_r <= S_OFFER;
              end
              default: begin
                o_idx_r <= IdxOutW'(pend_addr_r);
                state_r <= S_DONE;
              end
            endcase
          end else begin
            pend_r <= (k_r < n);
            rv_r <= pend_r;
            if (rv_r) begin
              have_r <= 1'b1;
              case (scan_r)
                SC_WORST: begin
                  if (take_lo) begin
                    best_v_r <= rdata;
                    best_i_r <= pend_addr_r;
                  end
                end
                SC_BEST: begin
                  if (take_hi) begin
                    best_v_r <= rdata;
                    best_i_r <= pend_addr_r;
                  end
                end
                default: acc_r <= acc_nxt;
              endcase
            end
          end
        end
        S_OFFER: begin
          // best: wait for the winning entry and remove the shift
          phase_r <= ~phase_r;
          if (phase_r) begin
            o_fit_r <= sat32(35'(rdata) - 35'(shift_r));
            state_r <= S_DONE;
          end
        end
        S_UNI: begin
          // restoring remainder, one bit a step
          if (bit_r == 0) begin
            o_idx_r <= IdxOutW'(umod_r);
            state_r <= S_DONE;
          end else begin
            if ({umod_r[30:0], rnd_r[31]} >= 32'(n)) begin
              umod_r <= {umod_r[30:0], rnd_r[31]} - 32'(n);
            end else begin
              umod_r <= {umod_r[30:0], rnd_r[31]};
            end
            rnd_r <= {rnd_r[30:0], 1'b0};
            bit_r <= bit_r - 1'b1;
          end
        end
        S_THR: begin
          // shift-add product of sum and random word
          if (bit_r == 0) begin
            scan_r <= SC_ROUL;
            state_r <= S_SCAN;
          end else begin
            prod_r <= (prod_r << 1) + (rnd_r[31] ? {32'd0, sum_r} : {(SumW+32){1'b0}});
            rnd_r <= {rnd_r[30:0], 1'b0};
            bit_r <= bit_r - 1'b1;
          end
        end
        S_FSHIFT: begin
          // read, add shift, write back
          if (!phase_r) begin
            addr_r <= k_r[AddrW-1:0];
            phase_r <= 1'b1;
            pend_r <= 1'b0;
          end else if (!pend_r) begin
            pend_r <= 1'b1;
          end else begin
            we_r <= 1'b1;
            waddr_r <= addr_r;
            wdata_r <= shifted;
            pend_r <= 1'b0;
            phase_r <= 1'b0;
            if (k_r == n - 1'b1) begin
              k_r <= '0;
              acc_r <= '0;
              state_r <= S_FSUM;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        S_FSUM: begin
          if (!phase_r) begin
            addr_r <= k_r[AddrW-1:0];
            phase_r <= 1'b1;
            pend_r <= 1'b0;
          end else if (!pend_r) begin
            pend_r <= 1'b1;
          end else begin
            acc_r <= acc_r + SumW'(rdata);
            pend_r <= 1'b0;
            phase_r <= 1'b0;
            if (k_r == n - 1'b1) begin
              sum_r <= acc_r + SumW'(rdata);
              worst_known_r <= 1'b0;
              state_r <= S_DONE;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          o_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign raddr = addr_r;
  assign out_valid = o_v_r;
  assign out_result_index = o_idx_r;
  assign out_result_fitness = o_fit_r;
  assign out_replaced = o_rep_r;
  assign out_selection_error = o_err_r;

`ifndef ASSERT_OFF
  a_err_no_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_replaced && out_selection_error)) else $error("err and replace");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
  a_busy_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
`endif
endmodule

### test/testbench.sv
// Self-checking testbench of the GA fitness table selector core, with random stimulus.
`timescale 1ns / 1ps
module testbench;
  import gafts_pkg::*;

  localparam logic [2:0] ReqSpare5 = 3'd5;
  localparam logic [2:0] ReqSpare7 = 3'd7;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned DrainCycles = 3 * TableDepth + 16;

  typedef struct packed {
    logic [2:0]         req;
    logic [9:0]         entry;
    logic signed [31:0] fit;
    logic [31:0]        rnd;
  } fit_request_t;

  typedef struct packed {
    logic [9:0]         idx;
    logic signed [31:0] fit;
    logic               rep;
    logic               err;
  } fit_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_req_type = '0;
  logic [9:0] in_entry_index = '0;
  logic signed [31:0] in_fitness = '0;
  logic [31:0] in_random_word = '0;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [IdxOutW-1:0] out_result_index;
  logic signed [FitW-1:0] out_result_fitness;
  logic out_replaced;
  logic out_selection_error;

  fit_request_t pending_items[$];
  fit_answer_t expected_answers[$];
  int fails = 0;
  int sent_count = 0;
  bit took = 1'b0;

  int tbl[TableDepth];
  longint sum_q;
  longint shift_amt;
  int unsigned worst_idx;
  bit worst_ok;
  int unsigned pop_reg = 1024;
  bit sel_mode = 1'b1;
  bit shift_en = 1'b1;

  ga_fitness_table_selector_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_entry_index(in_entry_index),
    .in_fitness(in_fitness), .in_random_word(in_random_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_result_index(out_result_index),
    .out_result_fitness(out_result_fitness), .out_replaced(out_replaced),
    .out_selection_error(out_selection_error)
  );

  always #5 clk = ~clk;

  function automatic longint wrap48(longint x);
    logic signed [47:0] t;
    t = x[47:0];
    return longint'(t);
  endfunction

  function automatic int clip32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  function automatic int unsigned live_size();
    if (pop_reg == 0) return 1;
    if (pop_reg > TableDepth) return TableDepth;
    return pop_reg;
  endfunction

  function automatic int unsigned worst_of(int unsigned n);
    int unsigned r;
    int unsigned i;
    int unsigned idx;
    int w;
    r = n % 4;
    idx = 0;
    w = 0;
    for (int unsigned k = 0; k < n; k++) begin
      i = (k < n - r) ? (r + k) : (k - (n - r));
      if (k == 0 || tbl[i] < w) begin
        w = tbl[i];
        idx = i;
      end
    end
    return idx;
  endfunction

  function automatic fit_answer_t apply_request(fit_request_t q);
    fit_answer_t a;
    int unsigned n;
    int unsigned i;
    int unsigned b;
    longint s;
    longint part;
    longint thr;
    longint unsigned su;
    longint unsigned rw;
    int cand;
    a = '0;
    n = live_size();
    case (q.req)
      ReqWrite: begin
        if (q.entry < n) begin
          sum_q = wrap48(sum_q + longint'(q.fit) - longint'(tbl[q.entry]));
          tbl[q.entry] = q.fit;
          worst_ok = 1'b0;
        end
      end
      ReqFinalize: begin
        s = 0;
        if (shift_en) begin
          shift_amt = 1 - longint'(tbl[worst_of(n)]);
          for (i = 0; i < n; i++) tbl[i] = clip32(longint'(tbl[i]) + shift_amt);
        end
        for (i = 0; i < n; i++) s += longint'(tbl[i]);
        sum_q = wrap48(s);
        worst_ok = 1'b0;
      end
      ReqSelect: begin
        if (!sel_mode) begin
          a.idx = 10'(q.rnd % n);
        end else if (sum_q <= 0) begin
          a.err = 1'b1;
        end else begin
          su = sum_q;
          rw = {32'd0, q.rnd};
          thr = longint'((su >> 32) * rw + (((su & 64'hFFFF_FFFF) * rw) >> 32));
          part = 0;
          i = 0;
          do begin
            part += longint'(tbl[i]);
            i++;
          end while (i < n && part <= thr);
          a.idx = 10'(i - 1);
        end
      end
      ReqOffer: begin
        cand = clip32(longint'(q.fit) + shift_amt);
        if (!worst_ok || worst_idx >= n) begin
          worst_idx = worst_of(n);
          worst_ok = 1'b1;
        end
        a.idx = 10'(worst_idx);
        if (cand > tbl[worst_idx]) begin
          sum_q = wrap48(sum_q + longint'(cand) - longint'(tbl[worst_idx]));
          tbl[worst_idx] = cand;
          worst_ok = 1'b0;
          a.rep = 1'b1;
        end
      end
      ReqBest: begin
        b = 0;
        for (i = 1; i < n; i++) if (tbl[i] > tbl[b]) b = i;
        a.idx = 10'(b);
        a.fit = clip32(longint'(tbl[b]) - shift_amt);
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    fit_request_t q;
    if (rst_n && start && !busy) begin
      q.req = in_req_type;
      q.entry = in_entry_index;
      q.fit = in_fitness;
      q.rnd = in_random_word;
      expected_answers.push_back(apply_request(q));
      took = 1'b1;
    end
  end

  always @(posedge clk) begin
    fit_answer_t e;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $error("result with no item outstanding: index %0d", out_result_index);
        fails++;
      end else begin
        e = expected_answers.pop_front();
        if (out_result_index !== e.idx) begin
          $error("result_index expected %0d actual %0d", e.idx, out_result_index);
          fails++;
        end
        if (out_result_fitness !== e.fit) begin
          $error("result_fitness expected %0d actual %0d", e.fit, out_result_fitness);
          fails++;
        end
        if (out_replaced !== e.rep) begin
          $error("replaced expected %0d actual %0d", e.rep, out_replaced);
          fails++;
        end
        if (out_selection_error !== e.err) begin
          $error("selection_error expected %0d actual %0d", e.err, out_selection_error);
          fails++;
        end
      end
    end
  end

  always @(negedge clk) begin
    fit_request_t q;
    logic nstart;
    bit idle;
    nstart = start;
    if (took) begin
      took = 1'b0;
      nstart = 1'b0;
    end
    idle = !(sent_count >= 150 && sent_count < 300) && ($urandom_range(99) < 8);
    if (rst_n && !nstart && pending_items.size() > 0 && !idle) begin
      q = pending_items.pop_front();
      in_req_type <= q.req;
      in_entry_index <= q.entry;
      in_fitness <= q.fit;
      in_random_word <= q.rnd;
      nstart = 1'b1;
      sent_count++;
    end
    start <= nstart;
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_answers.size() > 0 || start || busy)
      @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CfgDataW-1:0];
    if (idx == CfgPopSize) begin
      pop_reg = val & 11'h7FF;
      worst_ok = 1'b0;
    end else if (idx == CfgSelMode) begin
      sel_mode = val[0];
    end else begin
      shift_en = val[0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_item(logic [2:0] req, logic [9:0] entry, int fit,
                                   logic [31:0] rnd);
    fit_request_t q;
    q.req = req;
    q.entry = entry;
    q.fit = fit;
    q.rnd = rnd;
    pending_items.push_back(q);
  endfunction

  function automatic int rand_fitness();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1, 65536 * 8);
      2: return -int'($urandom_range(0, 65536 * 4));
      3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom_range(0, 65536 * 64);
    endcase
  endfunction

  function automatic logic [2:0] rand_req();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 25) return ReqWrite;
    if (p < 33) return ReqFinalize;
    if (p < 63) return ReqSelect;
    if (p < 83) return ReqOffer;
    if (p < 95) return ReqBest;
    return 3'($urandom_range(5, 7));
  endfunction

  task automatic run_phase(int unsigned pop, bit mode, bit shen, int unsigned count);
    int unsigned n;
    int unsigned fill;
    wait_idle();
    write_reg(CfgPopSize, pop);
    write_reg(CfgSelMode, mode);
    write_reg(CfgShiftEn, shen);
    n = live_size();
    fill = (n < 16) ? n : 16;
    for (int unsigned i = 0; i < fill; i++) add_item(ReqWrite, 10'(i), rand_fitness(), $urandom);
    add_item(ReqFinalize, '0, $urandom, $urandom);
    for (int unsigned i = fill + 1; i < count; i++) begin
      add_item(rand_req(), ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(n - 1)),
               rand_fitness(), $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < TableDepth; i++) tbl[i] = 0;
    sum_q = 0;
    shift_amt = 0;
    worst_idx = 0;
    worst_ok = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_item(ReqBest, '0, '0, '0);
    add_item(ReqSelect, '0, '0, 32'hFFFF_FFFF);
    add_item(ReqOffer, '0, 32'sh8000_0000, '0);
    add_item(ReqWrite, 10'd1023, 32'sh7FFF_FFFF, '0);
    add_item(ReqWrite, 10'd0, 32'sh8000_0000, '0);
    add_item(ReqBest, '0, '0, '0);
    add_item(ReqFinalize, '0, '0, '0);
    add_item(ReqSelect, '0, '0, 32'hFFFF_FFFF);
    add_item(ReqSelect, '0, '0, '0);
    add_item(ReqBest, '0, '0, '0);
    add_item(ReqSpare7, 10'h3FF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    add_item(ReqSpare5, '0, '0, '0);
    add_item(ReqOffer, '0, 32'sh7FFF_FFFF, '0);
    add_item(ReqOffer, '0, 32'sh8000_0000, '0);

    wait_idle();
    write_reg(CfgPopSize, 6);
    add_item(ReqWrite, 10'd6, 32'sh0001_0000, '0);
    add_item(ReqWrite, 10'd5, -32'sh0002_0000, '0);
    add_item(ReqOffer, '0, 32'sh0000_0001, '0);
    add_item(ReqFinalize, '0, '0, '0);
    add_item(ReqSelect, '0, '0, 32'h8000_0000);

    run_phase(5, 1, 1, 60);
    run_phase(1, 0, 1, 30);
    run_phase(0, 1, 0, 30);
    run_phase(4, 1, 1, 60);
    run_phase(16, 0, 0, 60);
    run_phase(7, 1, 1, 60);
    run_phase(3, 1, 0, 40);
    run_phase(37, 1, 1, 60);
    run_phase(2, 0, 1, 40);
    run_phase(8, 1, 1, 60);
    run_phase(2047, 1, 1, 12);
    run_phase(1024, 0, 0, 10);
    run_phase(13, 1, 1, 40);

    while (pending_items.size() > 0 || expected_answers.size() > 0 || start)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
